// ----- rtl/edge_toggle_update_typer_core_macros.svh -----
// Assertion macros for the edge toggle update typer.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef EDGE_TOGGLE_UPDATE_TYPER_CORE_MACROS_SVH
`define EDGE_TOGGLE_UPDATE_TYPER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that the consequent holds in the same cycle as the antecedent.
`define ETTU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ettu check failed in the same cycle");

// Checks that the consequent holds in the cycle after the antecedent.
`define ETTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ettu check failed in the following cycle");

`else

`define ETTU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ETTU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/ettu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ettu_pkg;

	// Store geometry for the full vertex range.
	localparam int MaxVertices = 256;
	localparam int VtxW        = 8;
	localparam int CfgW        = 9;
	localparam int PairCount   = (MaxVertices * (MaxVertices - 1)) / 2;
	localparam int IdxW        = $clog2(PairCount);
	localparam int ProdW       = 2 * VtxW + 1;

	// The bit store is kept as words of WordW bits.
	localparam int WordW      = 32;
	localparam int BitW       = $clog2(WordW);
	localparam int WordCount  = (PairCount + WordW - 1) / WordW;
	localparam int WordAddrW  = $clog2(WordCount);

	// Word request from the index pipeline to the store.
	typedef struct packed {
		logic                 vld;
		logic                 bad;
		logic [WordAddrW-1:0] waddr;
		logic [BitW-1:0]      bitpos;
	} req_t;

	// Result of the read-modify-write stage.
	typedef struct packed {
		logic vld;
		logic bad;
		logic old;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/ettu_index.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ettu_index
	import ettu_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            take,
	input  wire logic [VtxW-1:0] edge_src,
	input  wire logic [VtxW-1:0] edge_dst,
	input  wire logic [CfgW-1:0] vertex_count,
	output req_t                 req
);

	localparam logic [VtxW:0] TwoMm1 = (VtxW + 1)'(2 * MaxVertices - 1);

	logic            bad_c;
	logic [VtxW-1:0] lo_c;
	logic [VtxW-1:0] hi_c;

	logic            v_s1;
	logic            bad_s1;
	logic [VtxW-1:0] lo_s1;
	logic [VtxW-1:0] col_s1;

	logic             v_s2;
	logic             bad_s2;
	logic [VtxW-1:0]  col_s2;
	logic [ProdW-1:0] prod_s2;

	logic [VtxW:0]    span_c;
	logic [ProdW-2:0] sum_c;
	logic [IdxW-1:0]  idx_c;

	// Range and self-loop check, endpoint ordering.
	always_comb begin
		bad_c = ({1'b0, edge_src} >= vertex_count) || ({1'b0, edge_dst} >= vertex_count) ||
			(edge_src == edge_dst);
		if (edge_src < edge_dst) begin
			lo_c = edge_src;
			hi_c = edge_dst;
		end else begin
			lo_c = edge_dst;
			hi_c = edge_src;
		end
	end

	// Stage one holds the row and the column of the pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s1 <= bad_c;
			lo_s1  <= lo_c;
			col_s1 <= hi_c - lo_c - VtxW'(1);
		end
	end

	// Stage two holds the row offset product of the triangular layout.
	assign span_c = TwoMm1 - {1'b0, lo_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s2  <= bad_s1;
			col_s2  <= col_s1;
			prod_s2 <= ProdW'({{(VtxW + 1){1'b0}}, lo_s1} * {{VtxW{1'b0}}, span_c});
		end
	end

	// The product is always even, so halving it is exact.
	assign sum_c = prod_s2[ProdW-1:1] + (ProdW - 1)'(col_s2);
	assign idx_c = sum_c[IdxW-1:0];

	always_comb begin
		req.vld    = v_s2;
		req.bad    = bad_s2;
		req.waddr  = idx_c[IdxW-1:BitW];
		req.bitpos = idx_c[BitW-1:0];
	end

endmodule

`default_nettype wire

// ----- rtl/ettu_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ettu_store
	import ettu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  req_t      req,
	output logic      busy,
	output res_t      res
);

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} clr_state_t;

	clr_state_t           state_q;
	logic [WordAddrW-1:0] clr_addr_q;

	logic [WordW-1:0] mem [WordCount];
	logic [WordW-1:0] rdata_q;

	logic                 v_s3;
	logic                 bad_s3;
	logic [WordAddrW-1:0] waddr_s3;
	logic [BitW-1:0]      bitpos_s3;
	logic                 fwd_s3;
	logic [WordW-1:0]     fwd_data_s3;

	logic                 re;
	logic                 item_we;
	logic [WordW-1:0]     word_cur;
	logic [WordW-1:0]     word_new;
	logic                 we;
	logic [WordAddrW-1:0] wa;
	logic [WordW-1:0]     wd;

	assign busy = (state_q == ST_CLEAR);

	// Clearing pass: one word per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + WordAddrW'(1);
					if (clr_addr_q == WordAddrW'(WordCount - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Current word, taking the write that coincided with this read.
	assign word_cur = fwd_s3 ? fwd_data_s3 : rdata_q;
	assign word_new = word_cur ^ (WordW'(1) << bitpos_s3);
	assign item_we  = adv && v_s3 && !bad_s3;
	assign re       = adv && req.vld && !req.bad;

	// Write port shared by the clearing pass and the toggle write-back.
	always_comb begin
		if (busy) begin
			we = 1'b1;
			wa = clr_addr_q;
			wd = '0;
		end else begin
			we = item_we;
			wa = waddr_s3;
			wd = word_new;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_q <= mem[req.waddr];
		end
	end

	// Stage three: read data arrives, old bit is picked and the word written back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s3      <= req.bad;
			waddr_s3    <= req.waddr;
			bitpos_s3   <= req.bitpos;
			fwd_s3      <= item_we && (req.waddr == waddr_s3);
			fwd_data_s3 <= word_new;
		end
	end

	always_comb begin
		res.vld = v_s3;
		res.bad = bad_s3;
		res.old = word_cur[bitpos_s3] && !bad_s3;
	end

endmodule

`default_nettype wire

// ----- rtl/edge_toggle_update_typer_core.sv -----
// A beat passes stage one, two, three and the output register. Throughput:
// one edge beat per cycle unless busy or out_stall holds it; one read and
// one write of a 32-bit word each cycle, the write-back forwarded to a read
// of the same word. Reset: arst_n clears control state, sets vertex_count to
// 256; a clearing pass zeroes the 1020-word store while input is stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "edge_toggle_update_typer_core_macros.svh"

module edge_toggle_update_typer_core
	import ettu_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr_en,
	input  wire logic [CfgW-1:0] cfg_wr_data,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [VtxW-1:0] edge_src,
	input  wire logic [VtxW-1:0] edge_dst,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 update_kind,
	output logic                 bad_edge
);

	logic [CfgW-1:0] vertex_count_q;
	logic            out_valid_q;
	logic            kind_q;
	logic            bad_q;

	logic adv;
	logic take;
	logic busy;
	req_t req;
	res_t res;

	// Vertex count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CfgW'(MaxVertices);
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	// The pipeline moves whenever the output register is free or being drained.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = busy || !adv;
	assign take     = in_valid && !in_stall;

	ettu_index u_index (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.take         (take),
		.edge_src     (edge_src),
		.edge_dst     (edge_dst),
		.vertex_count (vertex_count_q),
		.req          (req)
	);

	ettu_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req    (req),
		.busy   (busy),
		.res    (res)
	);

	// Output register for the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q <= res.old;
			bad_q  <= res.bad;
		end
	end

	assign out_valid   = out_valid_q;
	assign update_kind = kind_q;
	assign bad_edge    = bad_q;

	// No result can be in flight during the clearing pass.
	`ETTU_ASSERT_SAME(a_no_out_while_clear, clk, arst_n, busy, !out_valid_q && !res.vld)
	// A rejected edge never reports a delete.
	`ETTU_ASSERT_SAME(a_bad_is_insert, clk, arst_n, out_valid_q && bad_q, !kind_q)
	// Once the clearing pass ends it never restarts without a reset.
	`ETTU_ASSERT_NEXT(a_clear_once, clk, arst_n, !busy, !busy)

endmodule

`default_nettype wire

// ----- tb/edge_toggle_update_typer_core_test.sv -----
`timescale 1ns / 1ps

module edge_toggle_update_typer_core_test;
	import ettu_pkg::*;

	localparam int HalfPeriod  = 10;
	localparam int ResetCycles = 11;
	localparam int PhaseItems  = 200;
	localparam int PhaseCount  = 8;
	localparam int HoldCycles  = 300;
	localparam int IdleLimit   = 5000;
	localparam int DrainCycles = 4;
	localparam int RecentDepth = 8;

	localparam bit KindInsert = 1'b0;
	localparam bit KindDelete = 1'b1;

	// Idling modes used by the random phases.
	typedef enum int {
		IdleNone,
		IdleSender,
		IdleReceiver,
		IdleBoth
	} idle_mode_t;

	// Keeps the pair store and the vertex count, and the results still owed by the block.
	class edge_toggle_scoreboard;
		typedef struct {
			bit kind;
			bit bad;
		} edge_result_t;

		bit           pair_present [PairCount];
		int unsigned  vertex_count;
		edge_result_t expected_results [$];
		int           errors;
		int           edge_beats;
		int           inserts;
		int           deletes;
		int           bad_edges;

		function new();
			vertex_count = MaxVertices;
			errors       = 0;
			edge_beats   = 0;
			inserts      = 0;
			deletes      = 0;
			bad_edges    = 0;
		endfunction

		function void set_vertex_count(int unsigned value);
			vertex_count = value;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Predicts one accepted edge beat and toggles the pair bit for a good edge.
		function void note_edge(bit [VtxW-1:0] src, bit [VtxW-1:0] dst);
			int unsigned  limit;
			int unsigned  lo;
			int unsigned  hi;
			int unsigned  pair_idx;
			edge_result_t res;
			limit = (vertex_count > MaxVertices) ? MaxVertices : vertex_count;
			edge_beats++;
			if (src >= limit || dst >= limit || src == dst) begin
				res.kind = KindInsert;
				res.bad  = 1'b1;
				bad_edges++;
			end else begin
				lo       = (src < dst) ? src : dst;
				hi       = (src < dst) ? dst : src;
				pair_idx = lo * (2 * MaxVertices - lo - 1) / 2 + (hi - lo - 1);
				res.kind = pair_present[pair_idx] ? KindDelete : KindInsert;
				res.bad  = 1'b0;
				pair_present[pair_idx] = !pair_present[pair_idx];
				if (res.kind == KindDelete) begin
					deletes++;
				end else begin
					inserts++;
				end
			end
			expected_results.insert(expected_results.size(), res);
		endfunction

		// Compares one result beat with the oldest prediction.
		function void check_result(logic kind, logic bad);
			edge_result_t res;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t ns: result beat with nothing pending (update_kind %b, bad_edge %b)",
					$time, kind, bad);
				return;
			end
			res = expected_results.pop_front();
			if (bad !== res.bad) begin
				errors++;
				$display("%0t ns: bad_edge expected %0d, actual %b", $time, res.bad, bad);
			end
			if (kind !== res.kind) begin
				errors++;
				$display("%0t ns: update_kind expected %0d, actual %b", $time, res.kind,
					kind);
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [CfgW-1:0] cfg_wr_data;
	logic            in_valid;
	logic            in_stall;
	logic [VtxW-1:0] edge_src;
	logic [VtxW-1:0] edge_dst;
	logic            out_valid;
	logic            out_stall;
	logic            update_kind;
	logic            bad_edge;

	edge_toggle_scoreboard pair_tracker;
	int                    sender_idle_pct = 0;
	int                    receiver_stall_pct = 0;
	bit                    hold_request = 1'b0;
	int                    idle_cycles = 0;
	int                    count_settings = 0;
	bit [2*VtxW-1:0]       recent_edges [$];
	int                    phase_vertex_counts [PhaseCount] =
		'{256, 300, 2, 17, 511, 64, 3, 256};

	edge_toggle_update_typer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.edge_src    (edge_src),
		.edge_dst    (edge_dst),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.update_kind (update_kind),
		.bad_edge    (bad_edge)
	);

	// Clock with a 20 ns period.
	always begin
		#HalfPeriod clk = 1'b1;
		#HalfPeriod clk = 1'b0;
	end

	// Receiver side: random stalls, or one long hold-off when asked.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(negedge clk);
				hold_request = 1'b0;
				out_stall <= ($urandom_range(99) < receiver_stall_pct);
			end else begin
				out_stall <= ($urandom_range(99) < receiver_stall_pct);
			end
		end
	end

	// Both channels are observed at the rising edge; the watchdog runs off the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall === 1'b0) begin
				pair_tracker.note_edge(edge_src, edge_dst);
			end
			if (out_valid === 1'b1 && !out_stall) begin
				pair_tracker.check_result(update_kind, bad_edge);
			end
		end
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
		if (idle_cycles >= IdleLimit) begin
			$display("Watchdog: no beat for %0d cycles, %0d results still pending",
				IdleLimit, pair_tracker.pending());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offers one edge beat, with random sender gaps before it, and waits until it is taken.
	task automatic send_edge(input bit [VtxW-1:0] src, input bit [VtxW-1:0] dst);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			edge_src <= VtxW'($urandom);
			edge_dst <= VtxW'($urandom);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		edge_src <= src;
		edge_dst <= dst;
		do begin
			@(posedge clk);
		end while (in_stall !== 1'b0);
		recent_edges.insert(recent_edges.size(), {src, dst});
		if (recent_edges.size() > RecentDepth)
			void'(recent_edges.pop_front());
	endtask

	// Stops offering and waits until every predicted result has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pair_tracker.pending() != 0) @(negedge clk);
	endtask

	// Changes the vertex count while the block is idle.
	task automatic write_vertex_count(input int unsigned value);
		drain_results();
		repeat (DrainCycles) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value[CfgW-1:0];
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		pair_tracker.set_vertex_count(value);
		count_settings++;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IdleNone: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 0;
			end
			IdleSender: begin
				sender_idle_pct    = 62;
				receiver_stall_pct = 0;
			end
			IdleReceiver: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 62;
			end
			default: begin
				sender_idle_pct    = 15;
				receiver_stall_pct = 15;
			end
		endcase
	endtask

	// Mostly good edges in range, often repeating a recent pair so bits flip back
	// and the same store word is hit back to back; the rest are bad edges.
	task automatic pick_edge(output bit [VtxW-1:0] src, output bit [VtxW-1:0] dst);
		int unsigned     limit;
		int unsigned     roll;
		bit [2*VtxW-1:0] pair;
		bit [VtxW-1:0]   swap;
		limit = (pair_tracker.vertex_count > MaxVertices) ? MaxVertices
			: pair_tracker.vertex_count;
		roll  = $urandom_range(99);
		if (limit < 2) begin
			src = VtxW'($urandom);
			dst = (roll < 20) ? src : VtxW'($urandom);
		end else if (roll < 10) begin
			// Bad edge: a self loop, or an endpoint past the vertex count.
			src = VtxW'($urandom);
			if (limit == MaxVertices || roll < 4) begin
				dst = src;
			end else begin
				src = VtxW'($urandom_range(MaxVertices - 1, limit));
				dst = VtxW'($urandom);
			end
		end else if (roll < 45 && recent_edges.size() != 0) begin
			pair = recent_edges[$urandom_range(recent_edges.size() - 1)];
			src  = pair[2*VtxW-1:VtxW];
			dst  = pair[VtxW-1:0];
		end else begin
			src = VtxW'($urandom_range(limit - 1));
			dst = VtxW'((src + 1 + $urandom_range(limit - 2)) % limit);
		end
		if ($urandom_range(1)) begin
			swap = src;
			src  = dst;
			dst  = swap;
		end
	endtask

	initial begin
		bit [VtxW-1:0] src;
		bit [VtxW-1:0] dst;
		pair_tracker = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		edge_src    = '0;
		edge_dst    = '0;
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed edges at the full vertex count: both endpoint orders, the
		// extreme vertices, self loops, and one pair toggled back to back.
		write_vertex_count(MaxVertices);
		send_edge(8'd0, 8'd1);
		send_edge(8'd1, 8'd0);
		send_edge(8'd0, 8'd255);
		send_edge(8'd255, 8'd0);
		send_edge(8'd254, 8'd255);
		send_edge(8'd255, 8'd254);
		send_edge(8'd0, 8'd0);
		send_edge(8'd255, 8'd255);
		send_edge(8'd128, 8'd127);
		send_edge(8'd3, 8'd4);
		send_edge(8'd4, 8'd3);
		send_edge(8'd3, 8'd4);

		// Smallest useful vertex count, then counts that reject every edge.
		write_vertex_count(2);
		send_edge(8'd1, 8'd0);
		send_edge(8'd1, 8'd2);
		write_vertex_count(0);
		send_edge(8'd0, 8'd1);
		write_vertex_count(1);
		send_edge(8'd0, 8'd0);
		send_edge(8'd1, 8'd0);

		// A count above the store size acts as the full size; a small count keeps
		// the bits of pairs it hides, and they return when the count goes up.
		write_vertex_count(511);
		send_edge(8'd255, 8'd0);
		send_edge(8'd254, 8'd255);
		write_vertex_count(5);
		send_edge(8'd4, 8'd3);
		send_edge(8'd5, 8'd0);
		send_edge(8'd128, 8'd127);
		write_vertex_count(MaxVertices);
		send_edge(8'd127, 8'd128);

		// Random phases, each with its own vertex count and idling mode.
		for (int p = 0; p < PhaseCount; p++) begin
			write_vertex_count(phase_vertex_counts[p]);
			set_idling(idle_mode_t'(p % 4));
			if (p == 4)
				hold_request = 1'b1;
			for (int n = 0; n < PhaseItems; n++) begin
				if (p == 1 && n == PhaseItems / 2)
					drain_results();
				pick_edge(src, dst);
				send_edge(src, dst);
			end
		end

		drain_results();
		repeat (DrainCycles * 2) @(posedge clk);
		if (pair_tracker.pending() != 0) begin
			pair_tracker.errors++;
			$display("%0t ns: %0d results never arrived", $time, pair_tracker.pending());
		end
		$display("Covered %0d edge beats over %0d vertex counts: %0d inserts, %0d deletes, %0d bad.",
			pair_tracker.edge_beats, count_settings, pair_tracker.inserts,
			pair_tracker.deletes, pair_tracker.bad_edges);
		$display("Idling: none, sender, receiver, both; one long receiver hold, one full drain.");
		if (pair_tracker.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ettu_pkg.sv
rtl/ettu_index.sv
rtl/ettu_store.sv
rtl/edge_toggle_update_typer_core.sv
tb/edge_toggle_update_typer_core_test.sv
